// ===== rtl/core/capt_pkg.sv =====
`timescale 1ns / 1ps

package capt_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 28;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_CLOCK_HZ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_REV = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTER_TOP    = 2'd2;

    // Field widths
    localparam int CLK_W  = 28;
    localparam int PPR_W  = 8;
    localparam int TOP_W  = 16;
    localparam int CAP_W  = 16;
    localparam int RPM_W  = 16;
    localparam int OVF_W  = 16;

    // Datapath widths: period in ticks, divisor, dividend (clock * 60), divider step count
    localparam int STEPS_W = 32;
    localparam int DEN_W   = STEPS_W + PPR_W;
    localparam int NUM_W   = 34;
    localparam int CNT_W   = 6;

    // Reset values of the registers
    localparam logic [CLK_W-1:0] CLK_RESET = 28'd108000000;
    localparam logic [PPR_W-1:0] PPR_RESET = 8'd7;
    localparam logic [TOP_W-1:0] TOP_RESET = 16'hFFFF;

    localparam logic [OVF_W-1:0] OVF_MAX = {OVF_W{1'b1}};
    localparam logic [RPM_W-1:0] RPM_MAX = {RPM_W{1'b1}};

endpackage

// ===== rtl/core/capture_tachometer_rpm.sv =====
// capture_tachometer_rpm: shaft speed from the period between tachometer edges.
//
// Input channel (i_in_valid / o_in_stall): one timer event per word. An
// overflow event (i_event_kind 0) counts a counter wrap; a capture event
// (i_event_kind 1) carries the latched counter value in i_capture_value.
// Output channel (o_out_valid / i_out_stall): one word per event, holding
// the current speed in o_rpm and o_rpm_updated set when this event made it.
// Configuration: plain write port, i_cfg_we with i_cfg_index and i_cfg_data;
// write only while the block is idle.
// Steps: an overflow event goes straight on to the output register; a
// capture runs three setup steps (ticks to the edge, difference, divisor
// product) and then a one-bit-per-cycle restoring divider that forms
// clock * 60 / (pulses * period). One event is in work at a time: no new
// one is taken until the last has been loaded into the output register.
// o_in_stall is high while an event is in work. A finished word sits in
// the output register; if the receiver stalls, the next event is still
// taken and runs up to the point of delivery, then waits for the register.
// Reset (synchronous, active low) clears overflow count, last capture and
// held speed, and reloads the register defaults.
`timescale 1ns / 1ps

module capture_tachometer_rpm (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [capt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [capt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_event_kind,
    input  logic [capt_pkg::CAP_W-1:0]      i_capture_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [capt_pkg::RPM_W-1:0]      o_rpm,
    output logic                            o_rpm_updated
);
    import capt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BASE,
        S_STEPS,
        S_DEN,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [CLK_W-1:0] r_clk_hz;
    logic [PPR_W-1:0] r_ppr;
    logic [TOP_W-1:0] r_top;

    // Persistent state
    logic [OVF_W-1:0] r_ovf;
    logic [CAP_W-1:0] r_last;
    logic [RPM_W-1:0] r_held;

    // Working registers
    logic [CAP_W-1:0]   r_cap;
    logic [STEPS_W-1:0] r_base;
    logic [STEPS_W-1:0] r_steps;
    logic               r_gt;
    logic [DEN_W-1:0]   r_den;
    logic [DEN_W-1:0]   r_rem;
    logic [NUM_W-1:0]   r_quo;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_upd;

    // Output register
    logic               r_out_valid;
    logic [RPM_W-1:0]   r_rpm;
    logic               r_rpm_updated;

    logic               in_take;
    logic               out_free;
    logic [PPR_W-1:0]   ppr_eff;
    logic [NUM_W-1:0]   num;
    logic [DEN_W:0]     rem_sh;
    logic               fits;
    logic [DEN_W-1:0]   n_rem;
    logic [NUM_W-1:0]   n_quo;
    logic [RPM_W-1:0]   n_rpm_sat;

    assign in_take  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // Zero pulses per revolution counts as one
    assign ppr_eff = (r_ppr == '0) ? PPR_W'(1) : r_ppr;

    // clock * 60 as (clock << 6) - (clock << 2)
    assign num = ({{(NUM_W-CLK_W){1'b0}}, r_clk_hz} << 6)
               - ({{(NUM_W-CLK_W){1'b0}}, r_clk_hz} << 2);

    // One restoring divider step: shift in the next dividend bit, subtract if it fits
    assign rem_sh    = {r_rem, r_quo[NUM_W-1]};
    assign fits      = rem_sh >= {1'b0, r_den};
    assign n_rem     = fits ? DEN_W'(rem_sh - {1'b0, r_den}) : DEN_W'(rem_sh);
    assign n_quo     = {r_quo[NUM_W-2:0], fits};
    assign n_rpm_sat = (|n_quo[NUM_W-1:RPM_W]) ? RPM_MAX : n_quo[RPM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_clk_hz      <= CLK_RESET;
            r_ppr         <= PPR_RESET;
            r_top         <= TOP_RESET;
            r_ovf         <= '0;
            r_last        <= '0;
            r_held        <= '0;
            r_out_valid   <= 1'b0;
            r_upd         <= 1'b0;
            r_gt          <= 1'b0;
            r_cnt         <= '0;
        end else begin
            // Register writes; indexes past the list are dropped
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TIMER_CLOCK_HZ: r_clk_hz <= i_cfg_data[CLK_W-1:0];
                    REG_PULSES_PER_REV: r_ppr    <= i_cfg_data[PPR_W-1:0];
                    REG_COUNTER_TOP:    r_top    <= i_cfg_data[TOP_W-1:0];
                    default: ;
                endcase
            end

            // Drop the output word once the receiver takes it; in S_DONE the
            // load below decides the valid bit
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_cap <= i_capture_value;
                        if (i_event_kind) begin
                            r_state <= S_BASE;
                        end else begin
                            // Count the wrap, saturating
                            if (r_ovf != OVF_MAX) begin
                                r_ovf <= r_ovf + OVF_W'(1);
                            end
                            r_upd   <= 1'b0;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_BASE: begin
                    // Ticks up to this edge: wraps times period plus capture
                    r_base  <= STEPS_W'(r_ovf) * STEPS_W'({1'b0, r_top} + 17'd1)
                             + STEPS_W'(r_cap);
                    r_state <= S_STEPS;
                end
                S_STEPS: begin
                    r_gt    <= r_base > STEPS_W'(r_last);
                    r_steps <= r_base - STEPS_W'(r_last);
                    r_ovf   <= '0;
                    r_last  <= r_cap;
                    r_state <= S_DEN;
                end
                S_DEN: begin
                    if (r_gt) begin
                        r_den   <= DEN_W'(ppr_eff) * DEN_W'(r_steps);
                        r_rem   <= '0;
                        r_quo   <= num;
                        r_cnt   <= CNT_W'(NUM_W - 1);
                        r_state <= S_DIV;
                    end else begin
                        // Period not positive: keep the held speed
                        r_upd   <= 1'b0;
                        r_state <= S_DONE;
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_held  <= n_rpm_sat;
                        r_upd   <= 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_rpm         <= r_held;
                        r_rpm_updated <= r_upd;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_rpm         = r_rpm;
    assign o_rpm_updated = r_rpm_updated;

endmodule

// ===== verif/capture_tachometer_rpm_tb.sv =====
`timescale 1ns / 1ps

module capture_tachometer_rpm_tb;
    import capt_pkg::*;

    localparam logic [63:0] SECONDS_PER_MINUTE = 64'd60;
    localparam logic [CLK_W-1:0] CLK_FULL = {CLK_W{1'b1}};
    localparam logic [PPR_W-1:0] PPR_FULL = {PPR_W{1'b1}};
    localparam logic [TOP_W-1:0] TOP_FULL = {TOP_W{1'b1}};

    typedef enum logic {
        EV_OVERFLOW = 1'b0,
        EV_CAPTURE  = 1'b1
    } t_tach_event;

    // One output word as the block should deliver it
    typedef struct packed {
        logic [RPM_W-1:0] rpm;
        logic             updated;
    } t_speed_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_TIMER_CLOCK_HZ;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_event_kind = EV_OVERFLOW;
    logic [CAP_W-1:0]      i_capture_value = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [RPM_W-1:0]      o_rpm;
    logic                  o_rpm_updated;

    // Stall bursts on the input (sender gaps) and output (receiver stalls)
    logic idle_in = 1'b0;
    logic idle_out = 1'b0;

    int mismatch_count = 0;

    // Expected output words, oldest first
    t_speed_word speed_expect_q[$];

    // Shadow of the configuration and of the speed state
    logic [CLK_W-1:0] cfg_clock_hz;
    logic [PPR_W-1:0] cfg_ppr;
    logic [TOP_W-1:0] cfg_top;
    logic [OVF_W-1:0] wraps_seen;
    logic [CAP_W-1:0] prev_capture;
    logic [RPM_W-1:0] speed_held;

    capture_tachometer_rpm uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_event_kind    (i_event_kind),
        .i_capture_value (i_capture_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_rpm           (o_rpm),
        .o_rpm_updated   (o_rpm_updated)
    );

    // 2 ns clock: 1 ns high, 1 ns low
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Advance the shadow state by one event and return the word it must produce.
    // Period = wraps * (top + 1) + capture - previous capture, all in 64 bits so
    // the widest case (65535 wraps of a 65536-tick counter) cannot overflow.
    function automatic t_speed_word predict_speed(input t_tach_event kind,
                                                  input logic [CAP_W-1:0] cap);
        logic [63:0] reach;
        logic [63:0] ticks;
        logic [63:0] divisor;
        logic [63:0] quotient;
        t_speed_word w;
        w.updated = 1'b0;
        if (kind == EV_OVERFLOW) begin
            // saturate the wrap count
            if (wraps_seen != OVF_MAX)
                wraps_seen = wraps_seen + OVF_W'(1);
        end else begin
            reach = 64'(wraps_seen) * (64'(cfg_top) + 64'd1) + 64'(cap);
            // only a positive period yields a new speed; otherwise hold the old one
            if (reach > 64'(prev_capture)) begin
                ticks    = reach - 64'(prev_capture);
                // zero pulses per revolution counts as one
                divisor  = ((cfg_ppr == '0) ? 64'd1 : 64'(cfg_ppr)) * ticks;
                quotient = (64'(cfg_clock_hz) * SECONDS_PER_MINUTE) / divisor;
                speed_held = (quotient > 64'(RPM_MAX)) ? RPM_MAX : quotient[RPM_W-1:0];
                w.updated = 1'b1;
            end
            // a capture always restarts the period
            wraps_seen   = '0;
            prev_capture = cap;
        end
        w.rpm = speed_held;
        return w;
    endfunction

    // Send one event word; predict its result once the block takes it.
    // Valid is left high afterwards so back-to-back words need no toggle.
    task automatic send_event(input t_tach_event kind, input logic [CAP_W-1:0] cap);
        t_speed_word w;
        @(negedge i_clk);
        if (idle_in && $urandom_range(0, 5) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_event_kind    = kind;
        i_capture_value = cap;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        w = predict_speed(kind, cap);
        speed_expect_q.push_back(w);
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic settle_block();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (speed_expect_q.size() != 0) @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);
    endtask

    // Write one register while the block is idle, and mirror it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        settle_block();
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_TIMER_CLOCK_HZ: cfg_clock_hz = data[CLK_W-1:0];
            REG_PULSES_PER_REV: cfg_ppr      = data[PPR_W-1:0];
            REG_COUNTER_TOP:    cfg_top      = data[TOP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CLK_W-1:0] clock_hz,
                              input logic [PPR_W-1:0] ppr,
                              input logic [TOP_W-1:0] top);
        write_reg(REG_TIMER_CLOCK_HZ, CFG_DATA_W'(clock_hz));
        write_reg(REG_PULSES_PER_REV, CFG_DATA_W'(ppr));
        write_reg(REG_COUNTER_TOP,    CFG_DATA_W'(top));
    endtask

    // Register defaults straight out of reset: no period yet, then a real
    // one, a zero period, a backward capture and a real one again.
    task automatic test_reset_defaults();
        idle_in  = 1'b0;
        idle_out = 1'b0;
        send_event(EV_CAPTURE,  16'd0);
        send_event(EV_OVERFLOW, 16'hFFFF);
        send_event(EV_CAPTURE,  16'd1000);
        send_event(EV_CAPTURE,  16'd1000);
        send_event(EV_CAPTURE,  16'd500);
        send_event(EV_CAPTURE,  16'd60000);
    endtask

    // Corner settings: saturated speed, zero clock, zero pulses, zero top,
    // captures past the counter top, one-tick and sub-one-rpm speeds.
    task automatic test_corner_cases();
        idle_in  = 1'b1;
        idle_out = 1'b1;
        set_config(CLK_FULL, 8'd1, TOP_FULL);
        send_event(EV_CAPTURE,  16'd1);
        send_event(EV_CAPTURE,  16'd2);
        set_config('0, PPR_FULL, 16'd100);
        send_event(EV_OVERFLOW, 16'd0);
        send_event(EV_CAPTURE,  16'd60000);
        send_event(EV_CAPTURE,  16'd65535);
        set_config(CLK_RESET, '0, '0);
        send_event(EV_OVERFLOW, 16'h5555);
        send_event(EV_OVERFLOW, 16'hAAAA);
        send_event(EV_CAPTURE,  16'd5);
        send_event(EV_OVERFLOW, 16'd0);
        send_event(EV_OVERFLOW, 16'd0);
        send_event(EV_OVERFLOW, 16'd0);
        send_event(EV_CAPTURE,  16'd9);
        set_config(28'd1, 8'd1, 16'd1);
        send_event(EV_CAPTURE,  16'd10);
        send_event(EV_CAPTURE,  16'd70);
        send_event(EV_CAPTURE,  16'd131);
        send_event(EV_OVERFLOW, 16'd0);
        send_event(EV_CAPTURE,  16'd0);
    endtask

    // A long string of wraps on a full-size counter, then a capture at the
    // top of the counter, so the period spans many counter periods.
    task automatic test_long_period();
        idle_in  = 1'b0;
        idle_out = 1'b0;
        set_config(CLK_FULL, 8'd1, TOP_FULL);
        send_event(EV_CAPTURE, 16'd0);
        repeat (24) send_event(EV_OVERFLOW, 16'd0);
        send_event(EV_CAPTURE, 16'hFFFF);
    endtask

    // One phase of random traffic under a random setting. Most words form
    // realistic runs (a few wraps, then a capture inside the period); the rest
    // is noise with any kind and any counter value.
    task automatic test_random_traffic(input int n_words, input logic allow_idle);
        int sent;
        int wraps;
        logic [CLK_W-1:0] clock_hz;
        logic [PPR_W-1:0] ppr;
        logic [TOP_W-1:0] top;
        sent = 0;
        idle_in  = allow_idle;
        idle_out = allow_idle;
        case ($urandom_range(0, 5))
            0: clock_hz = '0;
            1: clock_hz = 28'd1;
            2: clock_hz = CLK_FULL;
            default: clock_hz = CLK_W'($urandom_range(1, 250000000));
        endcase
        case ($urandom_range(0, 5))
            0: ppr = '0;
            1: ppr = 8'd1;
            2: ppr = PPR_FULL;
            default: ppr = PPR_W'($urandom_range(1, 255));
        endcase
        case ($urandom_range(0, 6))
            0: top = '0;
            1: top = 16'd1;
            2: top = TOP_FULL;
            3: top = TOP_W'($urandom_range(1, 255));
            default: top = TOP_W'($urandom_range(1, 65535));
        endcase
        set_config(clock_hz, ppr, top);
        while (sent < n_words) begin
            if ($urandom_range(0, 9) < 8) begin
                wraps = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 20)
                                                    : $urandom_range(0, 3);
                repeat (wraps) begin
                    send_event(EV_OVERFLOW, CAP_W'($urandom));
                    sent++;
                end
                send_event(EV_CAPTURE, CAP_W'($urandom_range(0, int'(cfg_top))));
                sent++;
            end else begin
                send_event($urandom_range(0, 1) ? EV_CAPTURE : EV_OVERFLOW,
                           CAP_W'($urandom));
                sent++;
            end
        end
    endtask

    // Receiver stall bursts; released at the falling edge
    initial begin
        forever begin
            @(negedge i_clk);
            if (idle_out && $urandom_range(0, 7) == 0) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
        end
    end

    // Compare every word the block hands over with the oldest expectation
    always @(posedge i_clk) begin : check_speed_word
        t_speed_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (speed_expect_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word rpm=%0d updated=%0b",
                                          o_rpm, o_rpm_updated));
            end else begin
                want = speed_expect_q.pop_front();
                if (o_rpm !== want.rpm)
                    report_mismatch($sformatf("rpm %0d, want %0d", o_rpm, want.rpm));
                if (o_rpm_updated !== want.updated)
                    report_mismatch($sformatf("rpm_updated %0b, want %0b",
                                              o_rpm_updated, want.updated));
            end
        end
    end

    initial begin
        // shadow registers and state as the block comes out of reset
        cfg_clock_hz = CLK_RESET;
        cfg_ppr      = PPR_RESET;
        cfg_top      = TOP_RESET;
        wraps_seen   = '0;
        prev_capture = '0;
        speed_held   = '0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_corner_cases();
        test_long_period();
        repeat (6) test_random_traffic(60, 1'b1);
        // last stretch runs with no stalls on either side
        test_random_traffic(60, 1'b0);

        settle_block();
        // hold a little longer to catch any stray word
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && speed_expect_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== capture_tachometer_rpm.f =====
rtl/core/capt_pkg.sv
rtl/core/capture_tachometer_rpm.sv
verif/capture_tachometer_rpm_tb.sv
